// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent assertion that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/pfbs_pkg.sv
// Package for the priority-first batch scheduler: sizes, item and entry types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfbs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int PID_W     = 4;
  localparam int PRIO_W    = 8;
  localparam int RT_W      = 16;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] priority_req;
    logic        [RT_W-1:0]   run_time;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic        [PID_W-1:0]  pid;
    logic signed [PRIO_W-1:0] priority_out;
    logic        [RT_W-1:0]   run_time_out;
    logic                     last_out;
  } out_item_t;

  typedef struct packed {
    logic        [PID_W-1:0]  pid;
    logic signed [PRIO_W-1:0] prio;
    logic        [RT_W-1:0]   rtime;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;   // insert the new entry into the chain this cycle
    logic drain;  // shift the chain one place toward cell 0
    logic held;   // this cell holds a stored entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/priority_first_batch_scheduler.sv
// Top level of the priority-first batch scheduler: sequencer and cell chain.
// Depends on pfbs_pkg and pfbs_cell.
//
//   channel   handshake                   payload
//   input     start (taken when !busy)     in_i   : in_item_t
//   result    result_valid_o strobe        out_o  : out_item_t
//
// The chain of cells keeps the batch sorted as items arrive, so each
// descriptor settles into place in the cycle it is accepted. The closing
// item is stored the same way, then the batch drains from cell 0 at one
// result per cycle, with busy high throughout. Reset is asynchronous and
// active low and empties the batch. The receiver cannot stall; every
// result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module priority_first_batch_scheduler
  import pfbs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire in_item_t  in_i,
  output logic           busy,
  output logic           result_valid_o,
  output out_item_t      out_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic   accept;
  logic   do_load;
  logic   do_drain;
  entry_t new_entry;

  entry_t                 cells [MAX_PROCS];
  logic   [MAX_PROCS-1:0] ins;

  // An item is taken only while loading; it is stored when room remains.
  // A full batch drops the descriptor, but a closing flag still counts.
  assign accept   = start && (state_q == ST_LOAD);
  assign do_load  = accept && (count_q < CNT_W'(MAX_PROCS));
  assign do_drain = (state_q == ST_DRAIN);

  // The arrival number is the fill count at the time of arrival.
  assign new_entry.pid   = PID_W'(count_q);
  assign new_entry.prio  = in_i.priority_req;
  assign new_entry.rtime = in_i.run_time;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_LOAD: begin
        if (do_load) begin
          count_d = count_q + CNT_W'(1);
        end
        if (accept && in_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        count_d = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // The chain is sorted by descending priority from cell 0. Each cell
  // decides locally whether the new entry belongs at or left of it; the
  // first such cell takes the new entry and the ones behind it take their
  // left neighbor. While draining, every cell takes its right neighbor.
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    entry_t    left_e;
    entry_t    right_e;
    logic      left_ins;
    cell_ctl_t ctl;

    if (g == 0) begin : g_head
      assign left_e   = '0;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_e   = cells[g-1];
      assign left_ins = ins[g-1];
    end

    if (g == MAX_PROCS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[g+1];
    end

    assign ctl.load  = do_load;
    assign ctl.drain = do_drain;
    assign ctl.held  = (CNT_W'(g) < count_q);

    pfbs_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .new_i      (new_entry),
      .left_i     (left_e),
      .left_ins_i (left_ins),
      .right_i    (right_e),
      .ins_o      (ins[g]),
      .entry_o    (cells[g])
    );
  end

  // Cell 0 always holds the next process in dispatch order.
  assign busy                = do_drain;
  assign result_valid_o      = do_drain;
  assign out_o.pid           = cells[0].pid;
  assign out_o.priority_out  = cells[0].prio;
  assign out_o.run_time_out  = cells[0].rtime;
  assign out_o.last_out      = do_drain && (count_q == CNT_W'(1));

endmodule

`default_nettype wire

// File: hw/rtl/pfbs_cell.sv
// One cell of the sorted insertion chain: holds one process entry.
// Depends on pfbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfbs_cell
  import pfbs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire cell_ctl_t ctl_i,
  input  wire entry_t    new_i,
  input  wire entry_t    left_i,
  input  wire logic      left_ins_i,
  input  wire entry_t    right_i,
  output logic           ins_o,
  output entry_t         entry_o
);

  entry_t entry_q, entry_d;

  // The insertion point lies here or further left when this cell is empty
  // or the new priority is strictly higher; ties keep arrival order.
  assign ins_o = !ctl_i.held || (new_i.prio > entry_q.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load && ins_o) begin
      entry_d = left_ins_i ? left_i : new_i;
    end else if (ctl_i.drain) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: hw/rtl/pfbs_checker.sv
// Port-level checker for the priority-first batch scheduler, with its bind.
// Depends on pfbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfbs_checker
  import pfbs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire in_item_t  in_i,
  input wire logic      busy,
  input wire logic      result_valid_o,
  input wire out_item_t out_o
);

  logic closing;
  logic final_res;
  logic mid_res;

  assign closing   = start && !busy && in_i.last;
  assign final_res = result_valid_o && out_o.last_out;
  assign mid_res   = result_valid_o && !out_o.last_out;

  `ASSERT_CLK(a_result_only_busy, clk_i, rst_ni, result_valid_o |-> busy, "result while idle")
  `ASSERT_CLK(a_close_drains, clk_i, rst_ni, closing |=> result_valid_o, "no dispatch")
  `ASSERT_CLK(a_last_ends_batch, clk_i, rst_ni, final_res |=> !busy, "busy after final result")
  `ASSERT_CLK(a_drain_continues, clk_i, rst_ni, mid_res |=> result_valid_o, "gap in batch")
  `ASSERT_NEVER(a_last_flag_idle, clk_i, rst_ni, out_o.last_out && !result_valid_o, "stray last")

endmodule

bind priority_first_batch_scheduler pfbs_checker u_pfbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .in_i           (in_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .out_o          (out_o)
);

`default_nettype wire
